### hw/rtl/mnbs_pkg.sv
// Shared types and constants for the mnemonic binary search core.
package mnbs_pkg;

    localparam int NAME_DEPTH   = 2048;
    localparam int STRING_DEPTH = 8192;
    localparam int MAX_NAME_LEN = 32;
    localparam int LETTERS      = 26;

    localparam int NAME_AW   = $clog2(NAME_DEPTH);
    localparam int STRING_AW = $clog2(STRING_DEPTH);
    localparam int QLEN_W    = $clog2(MAX_NAME_LEN + 1);
    localparam int QIDX_W    = $clog2(MAX_NAME_LEN);
    localparam int RANGE_W   = 11;
    localparam int ADDR_W    = 13;

    typedef enum logic [1:0] {
        MODE_NAME   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_RANGE  = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PROBE,
        ST_WORD_WAIT,
        ST_WORD,
        ST_FETCH,
        ST_CMP,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Compare outcome of one probe.
    typedef enum logic [1:0] {
        CMP_LESS  = 2'd0,
        CMP_EQUAL = 2'd1,
        CMP_MORE  = 2'd2
    } cmp_t;

    // Map a 5-bit packed code to its character.
    function automatic logic [7:0] code_char(input logic [4:0] c);
        logic [7:0] r;
        if (c <= 5'd26)
            r = 8'd96 + {3'd0, c};
        else
            r = 8'd21 + {3'd0, c};
        return r;
    endfunction

endpackage

### hw/rtl/mnbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mnbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/mnemonic_binary_search_core.sv
// Top level of the mnemonic binary search core.
//
// Channel | Dir | Bits | Contents
// s_axis  | in  | 88   | mode, table_addr, name_word, string_byte, range_start,
//         |     |      | range_end, query_char, query_last (on tlast)
// m_axis  | out | 16   | found, inst_index
//
// Loads and non-final query characters are taken in the idle state, which they leave unchanged.
// A final character starts a binary search: setup, then at most floor(log2(range))+1 probes and,
// unless setup fails or a probe hits, one closing probe check, then the done state. Each probe
// passes the probe, word wait and word states for the name word, a fetch and a compare per
// matching character (string table read and compare), then the closing fetch or mismatching
// compare and the decision. The shared character compare and the single read port of each RAM
// keep these steps in sequence. rst_n clears letter ranges, the query buffer length and the
// control state. Input is not ready during a search; a finished search holds in its done
// state while the previous result still waits on m_axis_tready.
module mnemonic_binary_search_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], table_addr[14:2], name_word[46:15], string_byte[54:47],
    // range_start[65:55], range_end[76:66], query_char[84:77], zero pad
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // query_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], inst_index[11:1], zero pad
    output logic [15:0] m_axis_tdata
);
    import mnbs_pkg::*;

    // field unpacking
    logic [1:0]          in_mode;
    logic [ADDR_W-1:0]   in_addr;
    logic [31:0]         in_word;
    logic [7:0]          in_byte;
    logic [RANGE_W-1:0]  in_start, in_end;
    logic [7:0]          in_char;
    logic                in_acc;

    assign in_mode  = s_axis_tdata[1:0];
    assign in_addr  = s_axis_tdata[14:2];
    assign in_word  = s_axis_tdata[46:15];
    assign in_byte  = s_axis_tdata[54:47];
    assign in_start = s_axis_tdata[65:55];
    assign in_end   = s_axis_tdata[76:66];
    assign in_char  = s_axis_tdata[84:77];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    state_t state_reg, state_next;

    logic [RANGE_W-1:0] starts_reg [LETTERS];
    logic [RANGE_W-1:0] ends_reg   [LETTERS];
    logic [7:0]         qbuf_reg   [MAX_NAME_LEN];
    logic [QLEN_W-1:0]  qlen_reg;
    logic               qovf_reg;

    // search registers
    logic [RANGE_W:0]   base_reg, base_next;
    logic [RANGE_W:0]   lim_reg, lim_next;
    logic [RANGE_W:0]   probe_reg, probe_next;
    logic [31:0]        word_reg, word_next;
    logic [5:0]         nlen_reg, nlen_next;   // decoded name length
    logic [5:0]         pos_reg, pos_next;     // char position in name
    cmp_t               cmp_reg, cmp_next;
    logic               hit_reg, hit_next;     // search matched at probe_reg
    logic               found_reg, found_next;
    logic [RANGE_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    // RAMs
    logic [31:0] name_rdata;
    logic [7:0]  str_rdata;
    logic [NAME_AW-1:0]   name_raddr;
    logic [STRING_AW-1:0] str_raddr;
    logic [STRING_AW:0]   str_addr_full;

    mnbs_ram #(.WIDTH(32), .DEPTH(NAME_DEPTH)) u_name_ram (
        .clk   (clk),
        .we    (in_acc && in_mode == MODE_NAME && in_addr < ADDR_W'(NAME_DEPTH)),
        .waddr (in_addr[NAME_AW-1:0]),
        .wdata (in_word),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    mnbs_ram #(.WIDTH(8), .DEPTH(STRING_DEPTH)) u_str_ram (
        .clk   (clk),
        .we    (in_acc && in_mode == MODE_STRING
                && {1'b0, in_addr} < (ADDR_W+1)'(STRING_DEPTH)),
        .waddr (in_addr[STRING_AW-1:0]),
        .wdata (in_byte),
        .raddr (str_raddr),
        .rdata (str_rdata)
    );

    assign name_raddr = probe_reg[NAME_AW-1:0];

    // name word fields
    logic        w_packed;
    logic [3:0]  w_ps;
    logic [2:0]  w_ss;
    logic [11:0] w_pb, w_sb;
    assign w_packed = word_reg[31];
    assign w_pb = word_reg[11:0];
    assign w_ps = word_reg[15:12];
    assign w_sb = word_reg[27:16];
    assign w_ss = word_reg[30:28];

    // string address for the current char position
    always_comb
    begin
        if (pos_reg < {2'd0, w_ps})
            str_addr_full = (STRING_AW+1)'(w_pb) + (STRING_AW+1)'(pos_reg);
        else
            str_addr_full = (STRING_AW+1)'(w_sb) + (STRING_AW+1)'(pos_reg - {2'd0, w_ps});
    end
    assign str_raddr = str_addr_full[STRING_AW-1:0];

    // packed-code length
    logic [5:0] packed_len;
    always_comb
    begin
        packed_len = 6'd6;
        for (int i = 5; i >= 0; i--)
            if (word_next[5*i +: 5] == 5'd0)
                packed_len = 6'(i);
    end

    // current name char
    logic [7:0] name_char;
    logic [2:0] code_sel;
    assign code_sel = pos_reg[2:0];
    always_comb
    begin
        if (w_packed)
            name_char = code_char(word_reg[5*code_sel +: 5]);
        else if (str_addr_full < (STRING_AW+1)'(STRING_DEPTH))
            name_char = str_rdata;
        else
            name_char = 8'd0;
    end

    logic [7:0]         first_ch;
    logic [7:0]         letter;
    logic [4:0]         let_idx;
    logic [RANGE_W-1:0] l_start, l_end;
    logic [7:0]         q_char;
    assign first_ch = qbuf_reg[0];
    assign letter   = first_ch - 8'd97;
    assign let_idx  = letter[4:0];
    assign l_start  = (letter < 8'(LETTERS)) ? starts_reg[let_idx] : '0;
    assign l_end    = (letter < 8'(LETTERS)) ? ends_reg[let_idx] : '0;
    assign q_char   = qbuf_reg[pos_reg[QIDX_W-1:0]];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && in_mode == MODE_QUERY && s_axis_tlast)
                    state_next = ST_SETUP;
            ST_SETUP:
                if (qovf_reg || qlen_reg == '0 || letter >= 8'(LETTERS)
                    || l_start == '0 || l_end <= l_start)
                    state_next = ST_DONE;
                else
                    state_next = ST_PROBE;
            ST_PROBE:
                if (lim_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_WORD_WAIT;
            ST_WORD_WAIT: state_next = ST_WORD;
            ST_WORD:      state_next = ST_FETCH;
            ST_FETCH:
                if (pos_reg >= nlen_reg || pos_reg >= 6'(qlen_reg))
                    state_next = ST_DECIDE;
                else
                    state_next = ST_CMP;
            ST_CMP:
                if (name_char != q_char)
                    state_next = ST_DECIDE;
                else
                    state_next = ST_FETCH;
            ST_DECIDE:
                if (cmp_next == CMP_EQUAL)
                    state_next = ST_DONE;
                else
                    state_next = ST_PROBE;
            ST_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        base_next      = base_reg;
        lim_next       = lim_reg;
        probe_next     = probe_reg;
        word_next      = word_reg;
        nlen_next      = nlen_reg;
        pos_next       = pos_reg;
        cmp_next       = cmp_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_SETUP:
            begin
                hit_next  = 1'b0;
                base_next = {1'b0, l_start};
                lim_next  = {1'b0, l_end} - {1'b0, l_start};
            end
            ST_PROBE:
                probe_next = base_reg + {1'b0, lim_reg[RANGE_W:1]};
            ST_WORD_WAIT: ;
            ST_WORD:
            begin
                word_next = (probe_reg < (RANGE_W+1)'(NAME_DEPTH)) ? name_rdata : 32'd0;
                if (word_next[31])
                    nlen_next = packed_len;
                else
                    nlen_next = 6'(word_next[15:12]) + 6'(word_next[30:28]);
                pos_next = '0;
            end
            ST_FETCH:
                if (pos_reg >= nlen_reg || pos_reg >= 6'(qlen_reg))
                begin
                    if (6'(qlen_reg) == nlen_reg)
                        cmp_next = CMP_EQUAL;
                    else if (6'(qlen_reg) < nlen_reg)
                        cmp_next = CMP_LESS;
                    else
                        cmp_next = CMP_MORE;
                end
            ST_CMP:
                if (name_char != q_char)
                    cmp_next = (q_char < name_char) ? CMP_LESS : CMP_MORE;
                else
                    pos_next = pos_reg + 6'd1;
            ST_DECIDE:
                if (cmp_reg == CMP_EQUAL)
                    hit_next = 1'b1;
                else if (cmp_reg == CMP_MORE)
                begin
                    base_next = probe_reg + 1'b1;
                    lim_next  = (lim_reg - 1'b1) >> 1;
                end
                else
                    lim_next = lim_reg >> 1;
            ST_DONE:
                // output registers load only once the previous result is gone
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    idx_next       = hit_reg ? probe_reg[RANGE_W-1:0] : '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            qlen_reg      <= '0;
            qovf_reg      <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < LETTERS; i++)
            begin
                starts_reg[i] <= '0;
                ends_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            if (in_acc && in_mode == MODE_RANGE && in_addr < ADDR_W'(LETTERS))
            begin
                starts_reg[in_addr[4:0]] <= in_start;
                ends_reg[in_addr[4:0]]   <= in_end;
            end
            if (in_acc && in_mode == MODE_QUERY)
            begin
                if (qlen_reg < QLEN_W'(MAX_NAME_LEN))
                    qlen_reg <= qlen_reg + 1'b1;
                else
                    qovf_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE)
            begin
                qlen_reg <= '0;
                qovf_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        lim_reg   <= lim_next;
        probe_reg <= probe_next;
        word_reg  <= word_next;
        nlen_reg  <= nlen_next;
        pos_reg   <= pos_next;
        cmp_reg   <= cmp_next;
        hit_reg   <= hit_next;
        if (in_acc && in_mode == MODE_QUERY && qlen_reg < QLEN_W'(MAX_NAME_LEN))
            qbuf_reg[qlen_reg[QIDX_W-1:0]] <= in_char;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, idx_reg, found_reg};

`ifndef ASSERT_OFF
    // A result never sits unconsumed while a new search completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_axis_tready) |=> state_reg == ST_DONE)
        else $error("result overwritten");
    // Not found always reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !found_reg |-> idx_reg == '0)
        else $error("nonzero index on miss");
    // Query length never exceeds the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= QLEN_W'(MAX_NAME_LEN))
        else $error("query length overflow");
`endif

endmodule

### verif/tb_top.sv
// Testbench for the mnemonic binary search core: table loads, streamed queries, result checks.
`timescale 1ns / 1ps

module tb_top;
    import mnbs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    mnemonic_binary_search_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    typedef struct packed {
        logic        found;
        logic [10:0] idx;
    } lookup_t;

    // Shadow state of the core
    logic [31:0] words_m [NAME_DEPTH];
    logic [7:0]  bytes_m [STRING_DEPTH];
    logic [10:0] starts_m [LETTERS];
    logic [10:0] ends_m [LETTERS];
    logic [7:0]  qbuf_m [MAX_NAME_LEN];
    int          qlen_m;
    bit          qovf_m;

    lookup_t lookups_pending [$];
    int      mismatches;
    int      idle_cycles;
    int      burst_left;

    // Table contents that tests build: sorted names per letter
    string   names_by_letter [LETTERS][$];
    int      names_total;

    // Expand one name word, packed or string-table, to a name string
    function automatic string decode_word(input logic [31:0] w);
        string s;
        int    i;
        logic [4:0] c;
        s = "";
        if (w[31]) begin
            for (i = 0; i < 6; i++) begin
                c = w[5*i +: 5];
                if (c == 0)
                    break;
                s = {s, string'(c <= 26 ? 8'd96 + c : 8'd21 + c)};
            end
        end else begin
            for (i = 0; i < w[15:12]; i++)
                s = {s, string'(bytes_m[w[11:0] + i])};
            for (i = 0; i < w[30:28]; i++)
                s = {s, string'(bytes_m[w[27:16] + i])};
        end
        return s;
    endfunction

    // Bytes compare as unsigned values
    function automatic int order_names(input string q, input string n);
        int i;
        int m;
        m = q.len() < n.len() ? q.len() : n.len();
        for (i = 0; i < m; i++)
            if (q[i] != n[i])
                return $unsigned(q[i]) < $unsigned(n[i]) ? -1 : 1;
        if (q.len() == n.len())
            return 0;
        return q.len() < n.len() ? -1 : 1;
    endfunction

    // Binary search over the shadow tables
    function automatic lookup_t search_table();
        lookup_t r;
        string   q;
        int      i;
        int      letter;
        int      lo;
        int      lim;
        int      probe;
        int      c;
        r = '0;
        if (qovf_m || qlen_m == 0)
            return r;
        letter = int'(qbuf_m[0]) - 97;
        if (letter < 0 || letter >= LETTERS)
            return r;
        lo = starts_m[letter];
        if (lo == 0 || ends_m[letter] <= lo)
            return r;
        q = "";
        for (i = 0; i < qlen_m; i++)
            q = {q, string'(qbuf_m[i])};
        for (lim = ends_m[letter] - lo; lim != 0; lim >>= 1) begin
            probe = lo + (lim >> 1);
            c = order_names(q, decode_word(probe < NAME_DEPTH ? words_m[probe] : 32'd0));
            if (c > 0) begin
                lo = probe + 1;
                lim--;
            end else if (c == 0) begin
                r.found = 1'b1;
                r.idx = probe[10:0];
                return r;
            end
        end
        return r;
    endfunction

    // Send one transaction and update the shadow model on acceptance
    task automatic send_item(input mode_t md, input logic [12:0] addr, input logic [31:0] word,
                             input logic [7:0] sb, input logic [10:0] rs, input logic [10:0] re,
                             input logic [7:0] qc, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= {3'd0, qc, re, rs, sb, word, addr, md};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (md)
            MODE_NAME:   if (addr < NAME_DEPTH) words_m[addr] = word;
            MODE_STRING: if (addr < STRING_DEPTH) bytes_m[addr] = sb;
            MODE_RANGE:
                if (addr < LETTERS) begin
                    starts_m[addr] = rs;
                    ends_m[addr] = re;
                end
            default:
            begin
                if (qlen_m < MAX_NAME_LEN)
                    qbuf_m[qlen_m++] = qc;
                else
                    qovf_m = 1'b1;
                if (last) begin
                    lookups_pending.push_back(search_table());
                    qlen_m = 0;
                    qovf_m = 1'b0;
                end
            end
        endcase
        // tvalid stays up; the next transaction or a pause replaces it at this edge
        @(negedge clk);
    endtask

    task automatic send_query(input string q);
        int i;
        for (i = 0; i < q.len(); i++)
            send_item(MODE_QUERY, 13'($urandom), $urandom, 8'($urandom), 11'($urandom),
                      11'($urandom), q[i], i == q.len() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (lookups_pending.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    // Random name: a letter, then a-z/0-4; short ones may be packed, others use the string table
    function automatic string rand_name(input int letter);
        string s;
        int    n;
        int    i;
        s = string'(8'(97 + letter));
        n = $urandom_range(0, 7);
        for (i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(0, 3) == 0 ? $urandom_range(48, 52)
                                                      : $urandom_range(97, 122)))};
        return s;
    endfunction

    // Build and load a sorted table: word indices from 1 up, string bytes per unpacked name
    task automatic load_table(input int per_letter);
        int    l;
        int    i;
        int    j;
        int    sp;
        int    idx;
        string s;
        string t;
        bit    packable;
        logic [31:0] w;
        logic [4:0]  code;
        sp = 0;
        idx = 1;
        for (l = 0; l < LETTERS; l++) begin
            names_by_letter[l].delete();
            for (i = 0; i < per_letter; i++)
                names_by_letter[l].push_back(rand_name(l));
            names_by_letter[l].sort();
            for (i = names_by_letter[l].size() - 1; i > 0; i--)
                if (names_by_letter[l][i] == names_by_letter[l][i - 1])
                    names_by_letter[l].delete(i);
            send_item(MODE_RANGE, 13'(l), $urandom, 8'($urandom),
                      11'(idx), 11'(idx + names_by_letter[l].size()), 8'($urandom), 1'b0);
            foreach (names_by_letter[l][i]) begin
                s = names_by_letter[l][i];
                packable = s.len() <= 6 && $urandom_range(0, 1);
                if (packable) begin
                    w = 32'h8000_0000;
                    for (j = 0; j < s.len(); j++) begin
                        code = s[j] >= 97 ? 5'(s[j] - 96) : 5'(s[j] - 21);
                        w[5*j +: 5] = code;
                    end
                end else begin
                    // prefix up to 4 bytes, suffix up to 7 (names are at most 8 long)
                    t = s;
                    j = t.len() > 4 ? $urandom_range(t.len() - 4 > 1 ? t.len() - 4 : 1, 4)
                                    : $urandom_range(0, t.len());
                    if (t.len() - j > 7)
                        j = t.len() - 7;
                    for (int k = 0; k < t.len(); k++)
                        send_item(MODE_STRING, 13'(sp + k), $urandom, t[k], 11'($urandom),
                                  11'($urandom), 8'($urandom), 1'b0);
                    w = '0;
                    w[11:0]  = 12'(sp);
                    w[15:12] = 4'(j);
                    w[27:16] = 12'(sp + j);
                    w[30:28] = 3'(t.len() - j);
                    sp = (sp + t.len()) % 4000;
                end
                send_item(MODE_NAME, 13'(idx), w, 8'($urandom), 11'($urandom),
                          11'($urandom), 8'($urandom), 1'b0);
                idx++;
            end
        end
        names_total = idx;
    endtask

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[11:1]};
            if (lookups_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result found=%0d index=%0d", got.found, got.idx);
            end else begin
                want = lookups_pending.pop_front();
                if (got !== want || m_axis_tdata[15:12] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected found=%0d index=%0d, got %0d %0d",
                                 want.found, want.idx, got.found, got.idx);
                end
            end
        end
    end

    // Receiver stall pattern, with quiet stretches
    always @(negedge clk)
    begin
        int phase;
        phase = ($time / 8) % 512;
        m_axis_tready <= phase < 128 ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        string q;
        load_table(3);
        // hits at the first name of letter a and the last name of letter z
        send_query(names_by_letter[0][0]);
        send_query(names_by_letter[25][names_by_letter[25].size() - 1]);
        send_query("zzzzzzzzzzzzzz");
        send_query("0ab");                 // first char not a letter
        send_query({8'hff});
        send_query({8'h00, 8'h7a});
        q = "";
        for (int i = 0; i < 34; i++)
            q = {q, "a"};
        send_query(q);                     // overflow
        q = q.substr(0, 31);
        send_query(q);                     // exactly buffer size
        send_query("a");
        drain();
        // zero-start and empty ranges, ignored loads past the stores
        send_item(MODE_RANGE, 13'd2, '1, 8'hff, 11'd0, 11'h7ff, 8'h00, 1'b0);
        send_item(MODE_RANGE, 13'd3, '1, 8'hff, 11'd20, 11'd20, 8'h00, 1'b0);
        send_item(MODE_RANGE, 13'd26, '1, 8'hff, 11'd1, 11'h7ff, 8'h00, 1'b0);
        send_item(MODE_RANGE, 13'h1fff, '1, 8'hff, 11'h7ff, 11'h7ff, 8'hff, 1'b1);
        send_item(MODE_NAME, 13'h1fff, '1, 8'hff, 11'h7ff, 11'h7ff, 8'hff, 1'b1);
        send_item(MODE_NAME, 13'd2048, '1, 8'hff, 11'h7ff, 11'h7ff, 8'hff, 1'b1);
        send_query("cab");
        send_query("dab");
        send_query(names_by_letter[1][0]);
        drain();
    endtask

    task automatic test_random_queries(input int budget);
        string s;
        int    l;
        while (budget > 0) begin
            l = $urandom_range(0, LETTERS - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: s = names_by_letter[l][$urandom_range(0, names_by_letter[l].size() - 1)];
                5, 6:          s = rand_name(l);
                7:             s = names_by_letter[l][0].substr(0, 0);
                8:
                begin
                    s = "";
                    for (int i = $urandom_range(1, 40); i > 0; i--)
                        s = {s, string'(8'($urandom_range(1, 255)))};
                end
                default:
                begin
                    s = names_by_letter[l][$urandom_range(0, names_by_letter[l].size() - 1)];
                    s = {s, string'(8'($urandom_range(48, 122)))};
                end
            endcase
            send_query(s);
            budget -= s.len();
        end
    endtask

    task automatic test_reload();
        drain();                           // sender holds until all results are back
        load_table(2);
        test_random_queries(500);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        qlen_m = 0;
        qovf_m = 1'b0;
        foreach (starts_m[i])
        begin
            starts_m[i] = '0;
            ends_m[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_queries(700);
        test_reload();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
